// ===== design/fba_pkg.sv =====
package fba_pkg;

	// Field widths fixed by the item and result formats
	localparam int CMD_W     = 3;
	localparam int FRAME_W   = 16;
	localparam int LIM_W     = 17;
	localparam int HOLD_W    = 8;
	localparam int HOLDERS_W = 9;
	localparam int CNT_W     = 17;
	localparam int CFG_IDX_W = 1;

	// Sizing of the frame store
	localparam int NUM_FRAMES    = 65536;
	localparam int MAP_WORD_BITS = 32;
	localparam int ADDR_FRAMES   = 1 << FRAME_W;
	localparam int EFF_MAX       = (NUM_FRAMES < ADDR_FRAMES) ? NUM_FRAMES : ADDR_FRAMES;
	localparam int MAP_WORDS     = (EFF_MAX + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int MAP_AW        = $clog2(MAP_WORDS);
	localparam int BIT_W         = $clog2(MAP_WORD_BITS);
	localparam int HOLD_AW       = $clog2(EFF_MAX);
	localparam int NW_W          = MAP_AW + 1;

	localparam logic [LIM_W-1:0]   EFF_MAX_L     = LIM_W'(EFF_MAX);
	localparam logic [LIM_W-1:0]   LIMIT_RESET   = LIM_W'(65536);
	localparam logic [CNT_W-1:0]   USED_RESET    = CNT_W'(EFF_MAX);
	localparam logic [HOLD_AW:0]   MAP_WORDS_L   = (HOLD_AW + 1)'(MAP_WORDS);
	localparam logic [HOLD_AW-1:0] CLEAR_LAST    = HOLD_AW'(EFF_MAX - 1);
	localparam logic [HOLD_W-1:0]  HOLD_MAX      = 8'hFF;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHARE_ENABLE = 1'b1;

	// Command codes; the two codes above query mean nothing
	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 3'd0,
		CMD_FREE    = 3'd1,
		CMD_RESERVE = 3'd2,
		CMD_RELEASE = 3'd3,
		CMD_SHARE   = 3'd4,
		CMD_QUERY   = 3'd5
	} cmd_t;

	typedef logic [MAP_WORD_BITS-1:0] map_word_t;

	// One word of the search, as handed to the scan unit
	typedef struct packed {
		map_word_t         data;
		logic [MAP_AW-1:0] word;
		logic              first;
		logic              last;
		logic [BIT_W-1:0]  start_bit;
		logic [LIM_W-1:0]  lim;
	} scan_ctx_t;

	typedef struct packed {
		logic             found;
		map_word_t        onehot;
		logic [LIM_W-1:0] frame;
	} scan_res_t;

endpackage

// ===== design/fba_if.sv =====
interface fba_item_if;
	import fba_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [FRAME_W-1:0] frame;

	modport source (output valid, cmd, frame, input ready);
	modport sink (input valid, cmd, frame, output ready);
endinterface

interface fba_result_if;
	import fba_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 ok;
	logic [FRAME_W-1:0]   frame_out;
	logic [HOLDERS_W-1:0] holders;
	logic [CNT_W-1:0]     used_count;
	logic [CNT_W-1:0]     shared_count;

	modport source (output valid, ok, frame_out, holders, used_count, shared_count,
		input ready);
	modport sink (input valid, ok, frame_out, holders, used_count, shared_count,
		output ready);
endinterface

// ===== design/fba_ram.sv =====
module fba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/fba_scan.sv =====
module fba_scan (
	input  fba_pkg::scan_ctx_t ctx,
	output fba_pkg::scan_res_t res
);
	import fba_pkg::*;

	localparam int LW_W = LIM_W - BIT_W;

	logic [LW_W-1:0]  lim_word;
	logic [BIT_W-1:0] lim_rem;
	logic [LW_W-1:0]  word_x;
	map_word_t        lim_mask;
	map_word_t        start_lo;
	map_word_t        pos_mask;
	map_word_t        free_bits;
	map_word_t        lowest;
	logic [BIT_W-1:0] bit_idx;

	assign lim_word = ctx.lim[LIM_W-1:BIT_W];
	assign lim_rem  = ctx.lim[BIT_W-1:0];
	assign word_x   = LW_W'(ctx.word);
	assign start_lo = (map_word_t'(1) << ctx.start_bit) - map_word_t'(1);

	// Keep only frames below the limit
	always_comb begin
		if (word_x < lim_word) begin
			lim_mask = '1;
		end else if (word_x == lim_word) begin
			lim_mask = (map_word_t'(1) << lim_rem) - map_word_t'(1);
		end else begin
			lim_mask = '0;
		end
	end

	// First word starts at the hint, the word revisited after wrap stops short of it
	always_comb begin
		if (ctx.first) begin
			pos_mask = ~start_lo;
		end else if (ctx.last) begin
			pos_mask = start_lo;
		end else begin
			pos_mask = '1;
		end
	end

	// Isolate the lowest free bit and encode it
	assign free_bits = ~ctx.data & lim_mask & pos_mask;
	assign lowest    = free_bits & (~free_bits + map_word_t'(1));

	always_comb begin
		bit_idx = '0;
		for (int b = 0; b < MAP_WORD_BITS; b++) begin
			if (lowest[b]) begin
				bit_idx = bit_idx | BIT_W'(b);
			end
		end
	end

	assign res.found  = |free_bits;
	assign res.onehot = lowest;
	assign res.frame  = LIM_W'({ctx.word, bit_idx});

endmodule

// ===== design/frame_bitmap_allocator.sv =====
// Frame bitmap allocator with a next-fit search.
// Items arrive on the item channel (cmd, frame) and each gives exactly one
// beat on the result channel (ok, frame_out, holders, used_count,
// shared_count). Both channels move a beat when valid and ready are high.
// The user writes registers through cfg_we / cfg_index / cfg_wdata only while
// idle; the block does not enforce this. After reset a clearing pass sets every
// used bit and zeroes every hold count, one entry a cycle, over all EFF_MAX
// hold entries (65536 at the default size); item.ready stays low until it ends.
// Reserve, release, free, share and query go through map and hold reads, an
// update and the result load. Allocate scans one map word at a time through
// the shared scan unit and a registered RAM read, from the hint word on,
// wrapping once, until a word gives a free frame or the hint word is revisited.
// The next item is taken in the cycle after the result loads.
// A new item is accepted only when the block is idle; one result may wait
// in the output register while the next item is worked on. If the receiver
// stalls, the finished item holds in the last step until the output frees.
module frame_bitmap_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	fba_item_if.sink                       item,
	fba_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [fba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fba_pkg::LIM_W-1:0]      cfg_wdata
);
	import fba_pkg::*;

	typedef enum logic [6:0] {
		ST_CLEAR    = 7'b0000001,
		ST_IDLE     = 7'b0000010,
		ST_CMD_RD   = 7'b0000100,
		ST_CMD_EX   = 7'b0001000,
		ST_SCAN_RD  = 7'b0010000,
		ST_SCAN_CHK = 7'b0100000,
		ST_DONE     = 7'b1000000
	} state_t;

	state_t state_q;

	// Control state
	logic [HOLD_AW-1:0]   clr_cnt_q;
	logic [FRAME_W-1:0]   hint_q;
	logic [CNT_W-1:0]     used_total_q;
	logic [CNT_W-1:0]     shared_total_q;
	logic [LIM_W-1:0]     frame_limit_q;
	logic                 share_en_q;
	logic                 out_valid_q;

	// Item and working payload
	logic [CMD_W-1:0]     cmd_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [MAP_AW-1:0]    scan_w_q;
	logic [NW_W-1:0]      scan_k_q;
	logic [BIT_W-1:0]     start_bit_q;
	logic                 res_ok_q;
	logic [FRAME_W-1:0]   res_frame_q;
	logic [HOLDERS_W-1:0] res_holders_q;

	// Output register
	logic                 out_ok_q;
	logic [FRAME_W-1:0]   out_frame_q;
	logic [HOLDERS_W-1:0] out_holders_q;
	logic [CNT_W-1:0]     out_used_q;
	logic [CNT_W-1:0]     out_shared_q;

	// Memory ports
	logic                 map_we;
	logic [MAP_AW-1:0]    map_waddr;
	map_word_t            map_wdata;
	logic [MAP_AW-1:0]    map_raddr;
	map_word_t            map_rdata;
	logic                 hold_we;
	logic [HOLD_AW-1:0]   hold_waddr;
	logic [HOLD_W-1:0]    hold_wdata;
	logic [HOLD_W-1:0]    hold_rdata;

	logic [LIM_W-1:0]     lim;
	logic [LIM_W:0]       lim_up;
	logic [NW_W-1:0]      num_words;
	logic [FRAME_W-1:0]   start;
	logic [NW_W-1:0]      w_inc;
	logic [MAP_AW-1:0]    w_next;
	logic                 item_fire;
	logic                 out_load;
	logic [MAP_AW-1:0]    frame_word;
	map_word_t            frame_bit;
	logic                 map_bit;
	logic                 in_range;
	logic                 is_null;
	logic                 ex_hold_dec;
	logic                 ex_share;
	logic                 ex_map_set;
	logic                 ex_map_clr;
	logic                 scan_hit;
	logic [LIM_W-1:0]     hint_inc;
	scan_ctx_t            scan_ctx;
	scan_res_t            scan_res;

	// Effective limit and search geometry
	assign lim       = (frame_limit_q > EFF_MAX_L) ? EFF_MAX_L : frame_limit_q;
	assign lim_up    = {1'b0, lim} + (LIM_W + 1)'(MAP_WORD_BITS - 1);
	assign num_words = NW_W'(lim_up >> BIT_W);
	assign start     = ({1'b0, hint_q} < lim) ? hint_q : '0;
	assign w_inc     = {1'b0, scan_w_q} + NW_W'(1);
	assign w_next    = (w_inc == num_words) ? '0 : w_inc[MAP_AW-1:0];

	assign item.ready = (state_q == ST_IDLE);
	assign item_fire  = item.valid && item.ready;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	// Decode the addressed frame
	assign frame_word = MAP_AW'(frame_q >> BIT_W);
	assign frame_bit  = map_word_t'(1) << frame_q[BIT_W-1:0];
	assign map_bit    = |(map_rdata & frame_bit);
	assign in_range   = ({1'b0, frame_q} < lim);
	assign is_null    = (frame_q == '0);

	// Scan unit input
	assign scan_ctx.data      = map_rdata;
	assign scan_ctx.word      = scan_w_q;
	assign scan_ctx.first     = (scan_k_q == '0);
	assign scan_ctx.last      = (scan_k_q == num_words);
	assign scan_ctx.start_bit = start_bit_q;
	assign scan_ctx.lim       = lim;

	fba_scan u_scan (
		.ctx(scan_ctx),
		.res(scan_res)
	);

	assign scan_hit = (state_q == ST_SCAN_CHK) && scan_res.found;
	assign hint_inc = scan_res.frame + LIM_W'(1);

	// Decide the update of a single-frame command
	always_comb begin
		ex_hold_dec = 1'b0;
		ex_share    = 1'b0;
		ex_map_set  = 1'b0;
		ex_map_clr  = 1'b0;
		if (state_q == ST_CMD_EX) begin
			unique case (cmd_q)
				CMD_FREE: begin
					if (!is_null) begin
						if (share_en_q && in_range && hold_rdata != '0) begin
							ex_hold_dec = 1'b1;
						end else begin
							ex_map_clr = in_range && map_bit;
						end
					end
				end
				CMD_RESERVE: ex_map_set = in_range && !map_bit;
				CMD_RELEASE: ex_map_clr = in_range && map_bit;
				CMD_SHARE: begin
					ex_share = share_en_q && !is_null && in_range && (hold_rdata != HOLD_MAX);
				end
				default: ;
			endcase
		end
	end

	// Drive the memory ports
	always_comb begin
		map_we     = 1'b0;
		map_waddr  = frame_word;
		map_wdata  = map_rdata;
		map_raddr  = frame_word;
		hold_we    = 1'b0;
		hold_waddr = HOLD_AW'(frame_q);
		hold_wdata = hold_rdata;
		if (state_q == ST_CLEAR) begin
			map_we     = ({1'b0, clr_cnt_q} < MAP_WORDS_L);
			map_waddr  = MAP_AW'(clr_cnt_q);
			map_wdata  = '1;
			hold_we    = 1'b1;
			hold_waddr = clr_cnt_q;
			hold_wdata = '0;
		end else if (state_q == ST_SCAN_RD) begin
			map_raddr = scan_w_q;
		end else if (scan_hit) begin
			map_we    = 1'b1;
			map_waddr = scan_w_q;
			map_wdata = map_rdata | scan_res.onehot;
		end else begin
			map_we = ex_map_set || ex_map_clr;
			if (ex_map_set) begin
				map_wdata = map_rdata | frame_bit;
			end else begin
				map_wdata = map_rdata & ~frame_bit;
			end
			hold_we = ex_hold_dec || ex_share;
			if (ex_share) begin
				hold_wdata = hold_rdata + HOLD_W'(1);
			end else begin
				hold_wdata = hold_rdata - HOLD_W'(1);
			end
		end
	end

	fba_ram #(
		.WIDTH(MAP_WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map_ram (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.raddr(map_raddr),
		.rdata(map_rdata)
	);

	fba_ram #(
		.WIDTH(HOLD_W),
		.DEPTH(EFF_MAX)
	) u_hold_ram (
		.clk  (clk),
		.we   (hold_we),
		.waddr(hold_waddr),
		.wdata(hold_wdata),
		.raddr(HOLD_AW'(frame_q)),
		.rdata(hold_rdata)
	);

	// Sequencer, totals, hint and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_cnt_q      <= '0;
			hint_q         <= '0;
			used_total_q   <= USED_RESET;
			shared_total_q <= '0;
			frame_limit_q  <= LIMIT_RESET;
			share_en_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FRAME_LIMIT) begin
					frame_limit_q <= cfg_wdata;
				end else if (cfg_index == CFG_SHARE_ENABLE) begin
					share_en_q <= cfg_wdata[0];
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + HOLD_AW'(1);
					if (clr_cnt_q == CLEAR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_fire) begin
						if (item.cmd == CMD_ALLOC) begin
							state_q <= (lim == '0) ? ST_DONE : ST_SCAN_RD;
						end else if (item.cmd == CMD_FREE || item.cmd == CMD_RESERVE ||
							item.cmd == CMD_RELEASE || item.cmd == CMD_SHARE ||
							item.cmd == CMD_QUERY) begin
							state_q <= ST_CMD_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_CMD_RD: state_q <= ST_CMD_EX;
				ST_CMD_EX: begin
					if (ex_map_set) begin
						used_total_q <= used_total_q + CNT_W'(1);
					end else if (ex_map_clr && used_total_q != '0) begin
						used_total_q <= used_total_q - CNT_W'(1);
					end
					if (ex_share && hold_rdata == '0) begin
						shared_total_q <= shared_total_q + CNT_W'(1);
					end else if (ex_hold_dec && hold_rdata == HOLD_W'(1) &&
						shared_total_q != '0) begin
						shared_total_q <= shared_total_q - CNT_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_SCAN_RD: state_q <= ST_SCAN_CHK;
				ST_SCAN_CHK: begin
					if (scan_res.found) begin
						used_total_q <= used_total_q + CNT_W'(1);
						hint_q       <= (hint_inc >= lim) ? '0 : hint_inc[FRAME_W-1:0];
						state_q      <= ST_DONE;
					end else if (scan_ctx.last) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item capture, scan position and result fields
	always_ff @(posedge clk) begin
		if (item_fire) begin
			cmd_q         <= item.cmd;
			frame_q       <= item.frame;
			scan_w_q      <= MAP_AW'(start >> BIT_W);
			scan_k_q      <= '0;
			start_bit_q   <= start[BIT_W-1:0];
			res_ok_q      <= 1'b0;
			res_frame_q   <= '0;
			res_holders_q <= '0;
		end
		if (state_q == ST_CMD_EX) begin
			if (ex_share) begin
				res_ok_q <= 1'b1;
			end
			if (cmd_q == CMD_QUERY && !is_null && in_range) begin
				res_holders_q <= HOLDERS_W'(1) +
					(share_en_q ? HOLDERS_W'(hold_rdata) : HOLDERS_W'(0));
			end
		end
		if (state_q == ST_SCAN_CHK) begin
			if (scan_res.found) begin
				res_ok_q    <= 1'b1;
				res_frame_q <= scan_res.frame[FRAME_W-1:0];
			end else begin
				scan_k_q <= scan_k_q + NW_W'(1);
				scan_w_q <= w_next;
			end
		end
		if (out_load) begin
			out_ok_q      <= res_ok_q;
			out_frame_q   <= res_frame_q;
			out_holders_q <= res_holders_q;
			out_used_q    <= used_total_q;
			out_shared_q  <= shared_total_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.ok           = out_ok_q;
	assign result.frame_out    = out_frame_q;
	assign result.holders      = out_holders_q;
	assign result.used_count   = out_used_q;
	assign result.shared_count = out_shared_q;

endmodule
